// ===== hw/rtl/smm_pkg.sv =====
package smm_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MERGE_AMOUNT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MERGE_EQ_POWER = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_POSITION   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_BALANCE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MONO_INPUT     = 3'd4;

  localparam int MERGE_BITS = 13;
  localparam int PAN_BITS   = 14;

  localparam logic [MERGE_BITS-1:0]      FULL_MERGE = 13'd4096;
  localparam logic signed [PAN_BITS-1:0] PAN_LIMIT  = 14'sd4096;

  // merge gains are unsigned q1.14, pan gains are non-negative but carried signed
  localparam int GAIN_BITS     = 15;
  localparam int PAN_GAIN_BITS = 17;
  localparam int PAN_CALC_BITS = 18;
  localparam logic [GAIN_BITS-1:0]            ONE_Q14      = 15'd16384;
  localparam logic signed [PAN_CALC_BITS-1:0] ONE_Q14_PAN  = 18'sd16384;

  // digit-by-digit square root, one root bit per cycle
  localparam int RAD_BITS      = 30;
  localparam int ROOT_BITS     = 15;
  localparam int REM_BITS      = 18;
  localparam int SQRT_CNT_BITS = 4;
  localparam logic [SQRT_CNT_BITS-1:0] SQRT_LAST = 4'd14;

  localparam int FRAC_BITS = 28;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_end_out;
  } out_item_t;

endpackage

// ===== hw/rtl/stereo_mono_merge_pan_mixer.sv =====
// pipeline: six register stages, from the input register to the output register
// throughput: one pair per cycle barring stalls; independent stages, so bubbles collapse
// gain update: any config write reloads the gains through the 15-step square root
// input stalled while gains reload, also after reset
// reset: synchronous active low, config/control regs to defaults, pipeline emptied
module stereo_mono_merge_pan_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  smm_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output smm_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [smm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import smm_pkg::*;

  localparam int S        = SAMPLE_BITS;
  localparam int PROD1    = S + GAIN_BITS + 1;
  localparam int MIX_BITS = PROD1 + 1;
  localparam int PROD2    = MIX_BITS + PAN_GAIN_BITS;
  localparam int SUM_BITS = PROD2 + 1;
  localparam logic signed [SUM_BITS-1:0] RND = SUM_BITS'(64'd1 << (FRAC_BITS - 1));

  // configuration registers
  logic [MERGE_BITS-1:0]        cfg_merge_r;
  logic                         cfg_eq_r;
  logic signed [PAN_BITS-1:0]   cfg_pan_r;
  logic                         cfg_bal_r;
  logic                         cfg_mono_r;
  logic                         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_merge_r <= '0;
      cfg_eq_r    <= 1'b1;
      cfg_pan_r   <= '0;
      cfg_bal_r   <= 1'b0;
      cfg_mono_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MERGE_AMOUNT:   cfg_merge_r <= cfg_data[MERGE_BITS-1:0];
        CFG_MERGE_EQ_POWER: cfg_eq_r    <= cfg_data[0];
        CFG_PAN_POSITION:   cfg_pan_r   <= $signed(cfg_data[PAN_BITS-1:0]);
        CFG_PAN_BALANCE:    cfg_bal_r   <= cfg_data[0];
        CFG_MONO_INPUT:     cfg_mono_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // gain derivation
  logic                       start_r;
  logic                       gains_ok_r;
  logic                       done_main;
  logic                       done_other;
  logic                       done_w;
  logic [MERGE_BITS-1:0]      m_cl;
  logic [GAIN_BITS-1:0]       lin_main;
  logic [GAIN_BITS-1:0]       lin_other;
  logic [RAD_BITS-1:0]        rad_main;
  logic [RAD_BITS-1:0]        rad_other;
  logic [ROOT_BITS-1:0]       root_main;
  logic [ROOT_BITS-1:0]       root_other;
  logic signed [PAN_BITS-1:0] p_cl;
  logic signed [PAN_CALC_BITS-1:0] p4;
  logic signed [PAN_CALC_BITS-1:0] l1_c, l2_c, r1_c, r2_c;

  logic [GAIN_BITS-1:0]            gm_r, go_r;
  logic signed [PAN_GAIN_BITS-1:0] gl1_r, gl2_r, gr1_r, gr2_r;

  always_comb begin
    m_cl      = (cfg_merge_r > FULL_MERGE) ? FULL_MERGE : cfg_merge_r;
    lin_other = {1'b0, m_cl, 1'b0};
    lin_main  = ONE_Q14 - lin_other;
    rad_main  = {1'b0, lin_main, 14'd0};
    rad_other = {1'b0, lin_other, 14'd0};

    if (cfg_pan_r > PAN_LIMIT) begin
      p_cl = PAN_LIMIT;
    end else if (cfg_pan_r < -PAN_LIMIT) begin
      p_cl = -PAN_LIMIT;
    end else begin
      p_cl = cfg_pan_r;
    end
    p4 = {{2{p_cl[PAN_BITS-1]}}, p_cl, 2'b00};

    if (p4 > 0) begin
      l1_c = ONE_Q14_PAN - p4;
      l2_c = '0;
      r1_c = p4;
      r2_c = ONE_Q14_PAN;
    end else begin
      l1_c = ONE_Q14_PAN;
      l2_c = -p4;
      r1_c = '0;
      r2_c = ONE_Q14_PAN + p4;
    end
    if (cfg_bal_r) begin
      l1_c = l1_c + l2_c;
      l2_c = '0;
      r2_c = r2_c + r1_c;
      r1_c = '0;
    end
  end

  smm_isqrt u_sqrt_main (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .radicand (rad_main),
    .root     (root_main),
    .done     (done_main)
  );

  smm_isqrt u_sqrt_other (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .radicand (rad_other),
    .root     (root_other),
    .done     (done_other)
  );

  assign done_w = done_main && done_other;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= 1'b1;
      gains_ok_r <= 1'b0;
    end else begin
      start_r <= cfg_wr;
      if (cfg_wr || start_r) begin
        gains_ok_r <= 1'b0;
      end else if (done_w) begin
        gains_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_w) begin
      gm_r  <= cfg_eq_r ? root_main  : lin_main;
      go_r  <= cfg_eq_r ? root_other : lin_other;
      gl1_r <= l1_c[PAN_GAIN_BITS-1:0];
      gl2_r <= l2_c[PAN_GAIN_BITS-1:0];
      gr1_r <= r1_c[PAN_GAIN_BITS-1:0];
      gr2_r <= r2_c[PAN_GAIN_BITS-1:0];
    end
  end

  // pipeline
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic e1, e2, e3, e4, e5, e6;

  logic signed [S-1:0]        x1_r, y1_r;
  logic                       end1_r, end2_r, end3_r, end4_r, end5_r;
  logic signed [PROD1-1:0]    p_xm_r, p_yo_r, p_ym_r, p_xo_r;
  logic signed [MIX_BITS-1:0] a_r, b_r;
  logic signed [PROD2-1:0]    q_al_r, q_bl_r, q_br_r, q_ar_r;
  logic signed [SUM_BITS-1:0] sl_r, sr_r;
  out_item_t                  out_data_r;

  logic signed [GAIN_BITS:0]  gm_s, go_s;

  assign gm_s = $signed({1'b0, gm_r});
  assign go_s = $signed({1'b0, go_r});

  always_comb begin
    e6 = !out_valid_r || !out_stall;
    e5 = !v5_r || e6;
    e4 = !v4_r || e5;
    e3 = !v3_r || e4;
    e2 = !v2_r || e3;
    e1 = !v1_r || e2;
  end

  assign in_stall = !e1 || !gains_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (e1) v1_r <= in_valid && gains_ok_r;
      if (e2) v2_r <= v1_r;
      if (e3) v3_r <= v2_r;
      if (e4) v4_r <= v3_r;
      if (e5) v5_r <= v4_r;
      if (e6) out_valid_r <= v5_r;
    end
  end

  function automatic logic signed [S-1:0] round_sat(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] biased;
    logic signed [SUM_BITS-1:0] q;
    logic                       fits;
    biased = v + RND;
    q      = biased >>> FRAC_BITS;
    fits   = (q[SUM_BITS-1:S-1] == {(SUM_BITS-S+1){1'b0}})
          || (q[SUM_BITS-1:S-1] == {(SUM_BITS-S+1){1'b1}});
    if (fits) begin
      return q[S-1:0];
    end else if (q[SUM_BITS-1]) begin
      return {1'b1, {(S-1){1'b0}}};
    end else begin
      return {1'b0, {(S-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (e1) begin
      x1_r   <= in_data.left_in;
      y1_r   <= cfg_mono_r ? in_data.left_in : in_data.right_in;
      end1_r <= in_data.block_end;
    end
    if (e2) begin
      p_xm_r <= x1_r * gm_s;
      p_yo_r <= y1_r * go_s;
      p_ym_r <= y1_r * gm_s;
      p_xo_r <= x1_r * go_s;
      end2_r <= end1_r;
    end
    if (e3) begin
      a_r    <= $signed({p_xm_r[PROD1-1], p_xm_r}) + $signed({p_yo_r[PROD1-1], p_yo_r});
      b_r    <= $signed({p_ym_r[PROD1-1], p_ym_r}) + $signed({p_xo_r[PROD1-1], p_xo_r});
      end3_r <= end2_r;
    end
    if (e4) begin
      q_al_r <= a_r * gl1_r;
      q_bl_r <= b_r * gl2_r;
      q_br_r <= b_r * gr2_r;
      q_ar_r <= a_r * gr1_r;
      end4_r <= end3_r;
    end
    if (e5) begin
      sl_r   <= $signed({q_al_r[PROD2-1], q_al_r}) + $signed({q_bl_r[PROD2-1], q_bl_r});
      sr_r   <= $signed({q_br_r[PROD2-1], q_br_r}) + $signed({q_ar_r[PROD2-1], q_ar_r});
      end5_r <= end4_r;
    end
    if (e6) begin
      out_data_r.left_out      <= round_sat(sl_r);
      out_data_r.right_out     <= round_sat(sr_r);
      out_data_r.block_end_out <= end5_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_done_before_ok: assert property (@(posedge clk) disable iff (!rst_n)
    done_w |-> !gains_ok_r)
    else $error("gain reload finished while gains already marked ready");

  a_stage5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !e6) |=> (v5_r && $stable(sl_r) && $stable(sr_r)))
    else $error("blocked stage lost or changed its transaction");

  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v5_r) |=> !out_valid_r)
    else $error("output transaction repeated");

endmodule

// ===== hw/rtl/smm_isqrt.sv =====
module smm_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [smm_pkg::RAD_BITS-1:0]   radicand,
  output logic [smm_pkg::ROOT_BITS-1:0]  root,
  output logic                           done
);
  import smm_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [SQRT_CNT_BITS-1:0] cnt_r;
  logic [RAD_BITS-1:0]      x_r;
  logic [REM_BITS-1:0]      rem_r;
  logic [ROOT_BITS-1:0]     root_r;

  logic [REM_BITS-1:0]      rem_sh;
  logic [REM_BITS-1:0]      trial;
  logic                     fits;
  logic [REM_BITS-1:0]      rem_nxt;
  logic [ROOT_BITS-1:0]     root_nxt;

  always_comb begin
    rem_sh   = {rem_r[REM_BITS-3:0], x_r[RAD_BITS-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[ROOT_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == SQRT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[RAD_BITS-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule
